>>> hdl/cas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, types and helpers of the contrast adaptive sharpener.
// ----------------------------------------------------------------------------
package cas_pkg;

	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 24;
	localparam int COL_W       = 11;
	localparam int ROW_W       = 12;
	localparam int IMG_W_W     = 12;
	localparam int IMG_H_W     = 13;
	localparam int SHARP_W     = 9;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int GEO_W       = 14;
	localparam int DIV_N_W     = 25;
	localparam int DIV_D_W     = 17;
	localparam int DIV_CNT_W   = 5;
	localparam int AMP_W       = 16;
	localparam int PEAK_W      = 14;
	localparam int SUM_W       = 10;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int SHARP_MAX   = 256;
	localparam int WIDTH_RST   = 640;
	localparam int HEIGHT_RST  = 480;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHARP  = 2'd2;

	typedef enum logic [1:0] {
		DIV_RATIO = 2'd0,
		DIV_PEAK  = 2'd1,
		DIV_PIXEL = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     rd_en;
		logic     plan;
		logic     amp_init;
		logic     div_start;
		div_sel_t div_sel;
		logic [1:0] chan;
		logic [1:0] job;
		logic     amp_upd;
		logic     peak_store;
		logic     mult;
		logic     pix_store;
		logic     out_load;
		logic     run_end;
		logic     update;
	} cas_cmd_t;

	typedef struct packed {
		logic       div_done;
		logic [3:0] mask;
		logic       out_free;
	} cas_stat_t;

	function automatic logic [CHAN_W-1:0] chan_of(input logic [PIX_W-1:0] p,
		input logic [1:0] k);
		logic [CHAN_W-1:0] v;
		case (k)
			2'd0: v = p[7:0];
			2'd1: v = p[15:8];
			2'd2: v = p[23:16];
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> hdl/cas_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cas_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/cas_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cas_div
	import cas_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIV_N_W-1:0] num,
	input  wire logic [DIV_D_W-1:0] den,
	output      logic               done,
	output      logic [DIV_N_W-1:0] quo
);
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     shifted;
	logic [DIV_D_W+1:0]   diff;

	assign shifted = {rem_q, quo_q[DIV_N_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[DIV_D_W+1]) begin
				rem_q <= diff[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

>>> hdl/cas_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_datapath
// Line stores, window, counters, sharpening arithmetic and output register.
// ----------------------------------------------------------------------------
module cas_datapath
	import cas_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cas_cmd_t             cmd,
	output      cas_stat_t            stat,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [CHAN_W-1:0]    red,
	input  wire logic [CHAN_W-1:0]    green,
	input  wire logic [CHAN_W-1:0]    blue,
	output      logic [CHAN_W-1:0]    out_red,
	output      logic [CHAN_W-1:0]    out_green,
	output      logic [CHAN_W-1:0]    out_blue,
	output      logic [COL_W-1:0]     out_col,
	output      logic [ROW_W-1:0]     out_row,
	output      logic                 run_end,
	output      logic                 out_valid,
	input  wire logic                 out_ready
);
	localparam int CW = $clog2(MAX_WIDTH);

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [SHARP_W-1:0] sharp_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CW-1:0]      cx_q;
	logic [ROW_W-1:0]   cy_q;
	logic [PIX_W-1:0]   cur_q;
	logic [PIX_W-1:0]   win_q [6];
	logic [3:0]         mask_q;
	logic [AMP_W-1:0]   amp_q;
	logic [PEAK_W-1:0]  pk_q;
	logic [PEAK_W-1:0]  m_q;
	logic               neg_q;
	logic [CHAN_W-1:0]  res_q [3];
	logic               out_valid_q;

	logic [GEO_W-1:0]   weff;
	logic [IMG_H_W-1:0] heff;
	logic [CW-1:0]      cx_now;
	logic [ROW_W-1:0]   cy_now;
	logic               last_row;
	logic               last_col;
	logic               cx_one;
	logic [PIX_W-1:0]   tcol;
	logic [PIX_W-1:0]   mcol;
	logic [PIX_W-1:0]   ct;
	logic [PIX_W-1:0]   op [5];
	logic [CHAN_W-1:0]  v [5];
	logic [CHAN_W-1:0]  mn;
	logic [CHAN_W-1:0]  mx;
	logic [CHAN_W-1:0]  lim;
	logic [SUM_W-1:0]   sum4;
	logic [23:0]        prod;
	logic [23:0]        cshift;
	logic [SHARP_W-1:0] s_sat;
	logic [11:0]        s3;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic               div_done;
	logic [DIV_N_W-1:0] quo;
	logic [AMP_W-1:0]   ratio;
	logic [29:0]        amp_pk;
	logic [CW-1:0]      o_col;
	logic [ROW_W-1:0]   o_row;

	always_comb begin
		weff = GEO_W'(width_q);
		if (weff < GEO_W'(2)) begin
			weff = GEO_W'(2);
		end else if (weff > GEO_W'(MAX_WIDTH)) begin
			weff = GEO_W'(MAX_WIDTH);
		end
		heff = height_q;
		if (heff < IMG_H_W'(2)) begin
			heff = IMG_H_W'(2);
		end else if (heff > IMG_H_W'(MAX_HEIGHT)) begin
			heff = IMG_H_W'(MAX_HEIGHT);
		end
	end

	assign cx_now   = (GEO_W'(col_q) >= weff) ? '0 : col_q;
	assign cy_now   = (IMG_H_W'(row_q) >= heff) ? '0 : row_q;
	assign last_row = IMG_H_W'(cy_q) == heff - 1'b1;
	assign last_col = GEO_W'(cx_q) == weff - 1'b1;
	assign cx_one   = cx_q == CW'(1);
	assign ct       = (cy_q == ROW_W'(1)) ? cur_q : tcol;

	cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk     (clk),
		.wr_en   (cmd.plan),
		.wr_addr (cx_q),
		.wr_data (mcol),
		.rd_en   (cmd.rd_en),
		.rd_addr (cx_q),
		.rd_data (tcol)
	);

	cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk     (clk),
		.wr_en   (cmd.plan),
		.wr_addr (cx_q),
		.wr_data (cur_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (cx_q),
		.rd_data (mcol)
	);

	always_comb begin
		case (cmd.job)
			2'd0: begin
				op[0] = win_q[0];
				op[1] = cx_one ? mcol : win_q[4];
				op[2] = win_q[1];
				op[3] = mcol;
				op[4] = win_q[2];
			end
			2'd1: begin
				op[0] = win_q[1];
				op[1] = cx_one ? cur_q : win_q[5];
				op[2] = win_q[2];
				op[3] = cur_q;
				op[4] = win_q[1];
			end
			2'd2: begin
				op[0] = ct;
				op[1] = win_q[1];
				op[2] = mcol;
				op[3] = win_q[1];
				op[4] = cur_q;
			end
			default: begin
				op[0] = mcol;
				op[1] = win_q[2];
				op[2] = cur_q;
				op[3] = win_q[2];
				op[4] = mcol;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			v[i] = chan_of(op[i], cmd.chan);
		end
		mn = v[0];
		mx = v[0];
		for (int i = 1; i < 5; i++) begin
			if (v[i] < mn) mn = v[i];
			if (v[i] > mx) mx = v[i];
		end
		lim    = (mn < (8'hFF - mx)) ? mn : (8'hFF - mx);
		sum4   = SUM_W'(v[0]) + SUM_W'(v[1]) + SUM_W'(v[3]) + SUM_W'(v[4]);
		prod   = 24'(m_q) * 24'(sum4);
		cshift = {v[2], 16'h0000};
		s_sat  = (sharp_q > SHARP_W'(SHARP_MAX)) ? SHARP_W'(SHARP_MAX) : sharp_q;
		s3     = {3'b000, s_sat} + {2'b00, s_sat, 1'b0};
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_RATIO: begin
				div_num = DIV_N_W'({lim, 16'h0000});
				div_den = DIV_D_W'(mx);
			end
			DIV_PEAK: begin
				div_num = DIV_N_W'(1) << 24;
				div_den = DIV_D_W'(12'd2048 - s3);
			end
			DIV_PIXEL: begin
				div_num = DIV_N_W'(cshift - prod);
				div_den = DIV_D_W'(17'h10000 - {1'b0, m_q, 2'b00});
			end
			default: begin
				div_num = '0;
				div_den = DIV_D_W'(1);
			end
		endcase
	end

	cas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign ratio  = (mx == '0) ? '0 :
		((quo > DIV_N_W'(16'hFFFF)) ? 16'hFFFF : quo[AMP_W-1:0]);
	assign amp_pk = 30'(amp_q) * 30'(pk_q);

	assign o_col = cmd.job[1] ? cx_q : cx_q - 1'b1;
	assign o_row = cmd.job[0] ? cy_q : cy_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= IMG_W_W'(WIDTH_RST);
			height_q    <= IMG_H_W'(HEIGHT_RST);
			sharp_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WIDTH: begin
						width_q <= cfg_data[IMG_W_W-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_HEIGHT: begin
						height_q <= cfg_data[IMG_H_W-1:0];
						col_q    <= '0;
						row_q    <= '0;
					end
					REG_SHARP: sharp_q <= cfg_data[SHARP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : cy_q + 1'b1;
				end else begin
					col_q <= cx_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q <= {blue, green, red};
			cx_q  <= cx_now;
			cy_q  <= cy_now;
		end
		if (cmd.plan) begin
			mask_q[0] <= (cy_q != '0) && (cx_q != '0);
			mask_q[1] <= (cy_q != '0) && (cx_q != '0) && last_row;
			mask_q[2] <= (cy_q != '0) && (cx_q != '0) && last_col;
			mask_q[3] <= (cy_q != '0) && (cx_q != '0) && last_col && last_row;
		end
		if (cmd.amp_init) begin
			amp_q <= 16'hFFFF;
		end else if (cmd.amp_upd && (ratio < amp_q)) begin
			amp_q <= ratio;
		end
		if (cmd.peak_store) begin
			pk_q <= quo[PEAK_W-1:0];
		end
		if (cmd.mult) begin
			m_q <= amp_pk[29:16];
		end
		if (cmd.div_start && (cmd.div_sel == DIV_PIXEL)) begin
			neg_q <= prod > cshift;
		end
		if (cmd.pix_store) begin
			res_q[cmd.chan] <= neg_q ? '0 :
				((quo > DIV_N_W'(255)) ? 8'hFF : quo[CHAN_W-1:0]);
		end
		if (cmd.out_load) begin
			out_red   <= res_q[0];
			out_green <= res_q[1];
			out_blue  <= res_q[2];
			out_col   <= COL_W'(o_col);
			out_row   <= o_row;
			run_end   <= cmd.run_end;
		end
		if (cmd.update) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= ct;
			win_q[1] <= mcol;
			win_q[2] <= cur_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.div_done = div_done;
	assign stat.mask     = mask_q;
	assign stat.out_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

>>> hdl/cas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer: one pixel at a time, up to four results, shared divider.
// ----------------------------------------------------------------------------
module cas_ctrl
	import cas_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire cas_stat_t stat,
	output      cas_cmd_t  cmd
);
	typedef enum logic [12:0] {
		ST_IDLE       = 13'b0000000000001,
		ST_READ       = 13'b0000000000010,
		ST_PLAN       = 13'b0000000000100,
		ST_JOB        = 13'b0000000001000,
		ST_RATIO_GO   = 13'b0000000010000,
		ST_RATIO_WAIT = 13'b0000000100000,
		ST_PEAK_GO    = 13'b0000001000000,
		ST_PEAK_WAIT  = 13'b0000010000000,
		ST_MULT       = 13'b0000100000000,
		ST_PIX_GO     = 13'b0001000000000,
		ST_PIX_WAIT   = 13'b0010000000000,
		ST_EMIT       = 13'b0100000000000,
		ST_UPDATE     = 13'b1000000000000
	} state_t;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] job_q;
	logic [1:0] job_nxt;
	logic [1:0] chan_q;
	logic [1:0] chan_nxt;
	logic [3:0] later;

	assign later = stat.mask & (4'b1110 << job_q);

	always_comb begin
		state_nxt = state_q;
		job_nxt   = job_q;
		chan_nxt  = chan_q;
		cmd       = '0;
		cmd.job   = job_q;
		cmd.chan  = chan_q;
		cmd.div_sel = DIV_RATIO;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan  = 1'b1;
				job_nxt   = '0;
				state_nxt = ST_JOB;
			end
			ST_JOB: begin
				if (stat.mask[job_q]) begin
					cmd.amp_init = 1'b1;
					chan_nxt     = '0;
					state_nxt    = ST_RATIO_GO;
				end else if (job_q == 2'd3) begin
					state_nxt = ST_UPDATE;
				end else begin
					job_nxt = job_q + 1'b1;
				end
			end
			ST_RATIO_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_RATIO_WAIT;
			end
			ST_RATIO_WAIT: begin
				if (stat.div_done) begin
					cmd.amp_upd = 1'b1;
					if (chan_q == 2'd2) begin
						state_nxt = ST_PEAK_GO;
					end else begin
						chan_nxt  = chan_q + 1'b1;
						state_nxt = ST_RATIO_GO;
					end
				end
			end
			ST_PEAK_GO: begin
				cmd.div_sel   = DIV_PEAK;
				cmd.div_start = 1'b1;
				state_nxt     = ST_PEAK_WAIT;
			end
			ST_PEAK_WAIT: begin
				cmd.div_sel = DIV_PEAK;
				if (stat.div_done) begin
					cmd.peak_store = 1'b1;
					state_nxt      = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult  = 1'b1;
				chan_nxt  = '0;
				state_nxt = ST_PIX_GO;
			end
			ST_PIX_GO: begin
				cmd.div_sel   = DIV_PIXEL;
				cmd.div_start = 1'b1;
				state_nxt     = ST_PIX_WAIT;
			end
			ST_PIX_WAIT: begin
				cmd.div_sel = DIV_PIXEL;
				if (stat.div_done) begin
					cmd.pix_store = 1'b1;
					if (chan_q == 2'd2) begin
						state_nxt = ST_EMIT;
					end else begin
						chan_nxt  = chan_q + 1'b1;
						state_nxt = ST_PIX_GO;
					end
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.run_end  = later == '0;
					if (job_q == 2'd3) begin
						state_nxt = ST_UPDATE;
					end else begin
						job_nxt   = job_q + 1'b1;
						state_nxt = ST_JOB;
					end
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= '0;
			chan_q  <= '0;
		end else begin
			state_q <= state_nxt;
			job_q   <= job_nxt;
			chan_q  <= chan_nxt;
		end
	end
endmodule
`default_nettype wire

>>> hdl/contrast_adaptive_sharpener_top.sv
// Flow: one pixel in flight, which causes n = 0..4 results; each result runs seven
//   25-step divisions (three ratios, peak, three channels) through one shared
//   serial divider.
// Reset: arst_n clears control, counters, configuration and the output valid flag at once;
//   line stores and the working registers are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contrast_adaptive_sharpener_top
// Contrast adaptive sharpening of an RGB888 raster stream.
// ----------------------------------------------------------------------------
module contrast_adaptive_sharpener_top
	import cas_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [CHAN_W-1:0]    red,
	input  wire logic [CHAN_W-1:0]    green,
	input  wire logic [CHAN_W-1:0]    blue,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic [CHAN_W-1:0]    out_red,
	output      logic [CHAN_W-1:0]    out_green,
	output      logic [CHAN_W-1:0]    out_blue,
	output      logic [COL_W-1:0]     out_col,
	output      logic [ROW_W-1:0]     out_row,
	output      logic                 run_end
);
	cas_cmd_t  cmd;
	cas_stat_t stat;

	cas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cas_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_col   (out_col),
		.out_row   (out_row),
		.run_end   (run_end),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

`ifndef ASSERT_OFF
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("transfer accepted while previous pixel in work");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten before transfer");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !stat.div_done)
		else $error("divider finished too early");
`endif
endmodule
`default_nettype wire
